>>> design/fpms_pkg.sv
`default_nettype none

package fpms_pkg;

    // Sizing
    localparam int NEEDLE_MAX     = 16;
    localparam int PATH_MAX_BYTES = 4096;

    localparam int POS_W   = 5;
    localparam int LEN_W   = 5;
    localparam int CNT_W   = $clog2(PATH_MAX_BYTES + 2);
    localparam int PEN_W   = CNT_W - 6;
    localparam int COMMIT_W = 9;
    localparam int PEND_W   = 7;
    localparam int SCORE_W  = 10;
    localparam int CALC_W   = 13;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // Score clamp limits
    localparam int SCORE_MAX = 511;
    localparam int SCORE_MIN = -512;

    // Register indexes (byte address = 8 * index)
    typedef enum logic [1:0] {
        REG_NEEDLE_LOW  = 2'd0,
        REG_NEEDLE_HIGH = 2'd1,
        REG_NEEDLE_LEN  = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SEP   = 2'd1,
        CLS_ALNUM = 2'd2,
        CLS_OTHER = 2'd3
    } t_byte_class;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // ASCII-only case fold
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'd32;
        end
        return b;
    endfunction

    function automatic t_byte_class classify(input logic [7:0] b);
        if (b == CH_SLASH || b == CH_BACKSLASH) begin
            return CLS_SEP;
        end
        if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A)) begin
            return CLS_ALNUM;
        end
        return CLS_OTHER;
    endfunction

endpackage

`default_nettype wire

>>> design/fuzzy_path_match_scorer.sv
`default_nettype none

// Fuzzy path match scorer. Feed a candidate path one byte per item on the
// input channel, with i_last_byte set on its final byte; one result item
// (matched, score, length saturation flag) comes out per path, after that
// final byte. The needle (up to 16 bytes, case-insensitive greedy
// subsequence) is set over the APB port at byte addresses 0x00 (bytes 0-7),
// 0x08 (bytes 8-15) and 0x10 (length, clamped to 16); write it only while no
// path is in flight. Rate: one byte per clock, sustained unless a last byte
// waits behind a held result. A result item is registered: the last byte is
// captured in the input register, the scoring logic works on it there, and
// the result register loads when the scoring stage advances on it. A held
// result blocks the input only when a last byte is waiting behind it; other
// bytes keep flowing. The running state feeds back on itself each cycle, so
// the scoring stage is the single loop that sets the rate.
// Score = match bonuses + pending last-segment bonus - length/64, with
// length counted up to 4096; longer paths raise o_length_saturated.
module fuzzy_path_match_scorer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // path byte channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_path_byte,
    input  wire logic                          i_last_byte,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_matched,
    output logic signed [fpms_pkg::SCORE_W-1:0] o_match_score,
    output logic                               o_length_saturated,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpms_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fpms_pkg::DATA_W-1:0]   pwdata,
    output logic [fpms_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import fpms_pkg::*;

    // Configuration registers
    logic [63:0]      r_needle_low;
    logic [63:0]      r_needle_high;
    logic [LEN_W-1:0] r_needle_len;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // Running path state
    logic [POS_W-1:0]    r_pos;
    logic                r_prev_matched;
    t_byte_class         r_prev_class;
    logic [COMMIT_W-1:0] r_committed;
    logic [PEND_W-1:0]   r_pending;
    logic [CNT_W-1:0]    r_count;

    // Result register
    logic                      r_out_valid;
    logic                      r_matched;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_sat;

    // Next values
    logic [POS_W-1:0]    n_pos;
    logic                n_prev_matched;
    logic [COMMIT_W-1:0] n_committed;
    logic [PEND_W-1:0]   n_pending;
    logic [CNT_W-1:0]    n_count;
    logic                n_matched;
    logic signed [SCORE_W-1:0] n_score;
    logic                n_sat;

    logic                cfg_write;
    t_reg_idx            reg_idx;
    logic                out_free;
    logic                advance;
    logic                load_result;
    logic [LEN_W-1:0]    len;
    logic                active;
    logic [7:0]          needle_b;
    logic [127:0]        needle_all;
    t_byte_class         cls;
    logic                hit;
    logic [COMMIT_W-1:0] gain;
    logic [PEND_W-1:0]   pend_add;
    logic                found;
    logic [PEN_W-1:0]    penalty;
    logic signed [CALC_W-1:0] raw_score;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_NEEDLE_LOW:  prdata = r_needle_low;
            REG_NEEDLE_HIGH: prdata = r_needle_high;
            REG_NEEDLE_LEN:  prdata = {{(DATA_W - LEN_W){1'b0}}, r_needle_len};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_NEEDLE_LOW:  r_needle_low  <= pwdata;
                REG_NEEDLE_HIGH: r_needle_high <= pwdata;
                REG_NEEDLE_LEN:  r_needle_len  <= pwdata[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Scoring stage advances unless it must emit a result into a full,
    // stalled output register. Non-last bytes never wait on the output.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && (!r_last || out_free);
    assign load_result = advance && r_last;
    assign o_in_stall  = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_path_byte;
            r_last <= i_last_byte;
        end
    end

    // ---------------- scoring ----------------
    assign len        = (r_needle_len > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : r_needle_len;
    assign active     = r_pos < len;
    assign needle_all = {r_needle_high, r_needle_low};
    assign needle_b   = needle_all[{r_pos[3:0], 3'b000} +: 8];
    assign cls        = classify(r_byte);
    assign hit        = active && (fold_case(r_byte) == fold_case(needle_b));

    always_comb begin
        gain     = COMMIT_W'(1);
        pend_add = '0;
        if (cls == CLS_SEP) begin
            // separator match: only a doubled separator earns the 8
            if (r_prev_class == CLS_SEP) begin
                gain = gain + COMMIT_W'(8);
            end
        end else begin
            case (r_prev_class)
                CLS_NONE: pend_add = PEND_W'(16);
                CLS_SEP: begin
                    gain     = gain + COMMIT_W'(8);
                    pend_add = PEND_W'(8);
                end
                CLS_OTHER: pend_add = PEND_W'(4);
                default:   pend_add = '0;
            endcase
        end
        if (r_prev_matched) begin
            gain = gain + COMMIT_W'(2);
        end
        if (r_byte == needle_b) begin
            gain = gain + COMMIT_W'(1);
        end
    end

    always_comb begin
        n_pos          = r_pos;
        n_prev_matched = r_prev_matched;
        n_committed    = r_committed;
        n_pending      = r_pending;
        if (active) begin
            n_prev_matched = hit;
            if (hit) begin
                n_pos       = r_pos + POS_W'(1);
                n_committed = r_committed + gain;
                n_pending   = r_pending + pend_add;
            end
        end
        if (cls == CLS_SEP) begin
            n_pending = '0;
        end
        n_count = (r_count <= CNT_W'(PATH_MAX_BYTES)) ? r_count + CNT_W'(1) : r_count;
    end

    // Result from the post-update state
    always_comb begin
        n_sat     = n_count > CNT_W'(PATH_MAX_BYTES);
        penalty   = n_sat ? PEN_W'(PATH_MAX_BYTES / 64) : n_count[CNT_W-1:6];
        found     = n_pos >= len;
        n_matched = found;
        raw_score = $signed(CALC_W'(n_committed)) + $signed(CALC_W'(n_pending))
                    - $signed(CALC_W'(penalty));
        if (len == '0 || !found) begin
            n_score = '0;
        end else if (raw_score > CALC_W'(SCORE_MAX)) begin
            n_score = SCORE_W'(SCORE_MAX);
        end else if (raw_score < CALC_W'(SCORE_MIN)) begin
            n_score = SCORE_W'(SCORE_MIN);
        end else begin
            n_score = raw_score[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_prev_matched <= 1'b0;
            r_prev_class   <= CLS_NONE;
            r_committed    <= '0;
            r_pending      <= '0;
            r_count        <= '0;
        end else if (advance) begin
            if (r_last) begin
                // path done: back to path-start state
                r_pos          <= '0;
                r_prev_matched <= 1'b0;
                r_prev_class   <= CLS_NONE;
                r_committed    <= '0;
                r_pending      <= '0;
                r_count        <= '0;
            end else begin
                r_pos          <= n_pos;
                r_prev_matched <= n_prev_matched;
                r_prev_class   <= cls;
                r_committed    <= n_committed;
                r_pending      <= n_pending;
                r_count        <= n_count;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_matched <= n_matched;
            r_score   <= n_score;
            r_sat     <= n_sat;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_matched          = r_matched;
    assign o_match_score      = r_score;
    assign o_length_saturated = r_sat;

endmodule

`default_nettype wire

>>> design/fpms_checker.sv
`default_nettype none

module fpms_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_stall,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_stall,
    input wire logic                          i_matched,
    input wire logic signed [fpms_pkg::SCORE_W-1:0] i_match_score,
    input wire logic                          i_length_saturated
);
    import fpms_pkg::*;

    // Held result does not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_match_score)
            && $stable(i_matched) && $stable(i_length_saturated))
        else $error("result changed while stalled");

    // Unmatched path reports zero score
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_matched |-> i_match_score == '0)
        else $error("unmatched result with nonzero score");

    // Length penalty bounds the score from below
    a_score_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $signed(i_match_score) >= -(PATH_MAX_BYTES / 64))
        else $error("score below length penalty floor");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Input only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled with the output free");

endmodule

bind fuzzy_path_match_scorer fpms_checker u_fpms_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_stall         (o_in_stall),
    .i_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .i_matched          (o_matched),
    .i_match_score      (o_match_score),
    .i_length_saturated (o_length_saturated)
);

`default_nettype wire

>>> sim/path_score_checker.sv
`default_nettype none

// Watches the path byte, result and APB channels of the scorer, keeps its own
// running score per path and compares every result item against it.
module path_score_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic [7:0]                          i_path_byte,
    input  wire logic                                i_last_byte,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic                                i_matched,
    input  wire logic signed [fpms_pkg::SCORE_W-1:0] i_match_score,
    input  wire logic                                i_length_saturated,
    input  wire logic                                i_psel,
    input  wire logic                                i_penable,
    input  wire logic                                i_pwrite,
    input  wire logic                                i_pready,
    input  wire logic [fpms_pkg::ADDR_W-1:0]         i_paddr,
    input  wire logic [fpms_pkg::DATA_W-1:0]         i_pwdata,
    output int                                       o_fail_count,
    output int                                       o_results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fpms_pkg::*;

    typedef struct packed {
        logic                      matched;
        logic signed [SCORE_W-1:0] score;
        logic                      saturated;
    } t_path_verdict;

    t_path_verdict verdict_queue[$];
    int            mismatch_count = 0;

    // needle registers as last written
    logic [63:0] needle_lo = '0;
    logic [63:0] needle_hi = '0;
    logic [4:0]  needle_len = '0;

    // running state of the path in flight
    int unsigned match_pos     = 0;
    logic        last_hit      = 1'b0;
    t_byte_class last_kind     = CLS_NONE;
    int unsigned earned        = 0;
    int unsigned segment_bonus = 0;
    int unsigned path_len      = 0;

    initial begin
        o_fail_count      = 0;
        o_results_pending = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50) begin
            $display("%0t ns: scorer mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic t_byte_class byte_kind(input logic [7:0] c);
        logic digit;
        logic letter;
        digit  = (c >= "0" && c <= "9");
        letter = (to_lower(c) >= "a" && to_lower(c) <= "z");
        if (c == CH_SLASH || c == CH_BACKSLASH) begin
            return CLS_SEP;
        end
        return (digit || letter) ? CLS_ALNUM : CLS_OTHER;
    endfunction

    function automatic logic [7:0] needle_char(input int unsigned idx);
        return (idx < 8) ? needle_lo[8*idx +: 8] : needle_hi[8*(idx-8) +: 8];
    endfunction

    task automatic clear_path();
        match_pos     = 0;
        last_hit      = 1'b0;
        last_kind     = CLS_NONE;
        earned        = 0;
        segment_bonus = 0;
        path_len      = 0;
    endtask

    // Advance the running score by one path byte; on the last byte queue
    // the verdict the block must report.
    task automatic score_byte(input logic [7:0] c, input logic is_last);
        t_byte_class   kind;
        int unsigned   eff_len;
        int unsigned   gain;
        int unsigned   counted;
        logic [7:0]    target;
        int            total;
        t_path_verdict verdict;
        kind    = byte_kind(c);
        eff_len = (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : needle_len;
        if (path_len <= PATH_MAX_BYTES) begin
            path_len++;
        end
        if (match_pos < eff_len) begin
            target = needle_char(match_pos);
            if (to_lower(c) == to_lower(target)) begin
                gain = 1;
                if (kind == CLS_SEP) begin
                    if (last_kind == CLS_SEP) begin
                        gain += 8;
                    end
                end else if (last_kind == CLS_NONE) begin
                    segment_bonus += 16;
                end else if (last_kind == CLS_SEP) begin
                    gain          += 8;
                    segment_bonus += 8;
                end else if (last_kind == CLS_OTHER) begin
                    segment_bonus += 4;
                end
                if (last_hit) begin
                    gain += 2;
                end
                if (c == target) begin
                    gain += 1;
                end
                earned += gain;
                match_pos++;
                last_hit = 1'b1;
            end else begin
                last_hit = 1'b0;
            end
        end
        if (kind == CLS_SEP) begin
            segment_bonus = 0;
        end
        last_kind = kind;
        if (is_last) begin
            verdict.saturated = (path_len > PATH_MAX_BYTES);
            counted = verdict.saturated ? PATH_MAX_BYTES : path_len;
            verdict.matched = (match_pos >= eff_len);
            total = 0;
            if (eff_len != 0 && verdict.matched) begin
                total = int'(earned + segment_bonus) - int'(counted / 64);
                if (total > SCORE_MAX) begin
                    total = SCORE_MAX;
                end
                if (total < SCORE_MIN) begin
                    total = SCORE_MIN;
                end
            end
            verdict.score = SCORE_W'(total);
            verdict_queue = {verdict_queue, verdict};
            clear_path();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_path_verdict want;
        if (!i_rst_n) begin
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = '0;
            clear_path();
            verdict_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch("result item with no path outstanding");
                end else begin
                    want = verdict_queue.pop_front();
                    if (i_matched !== want.matched) begin
                        report_mismatch($sformatf("matched: expected %0d, got %0b",
                                                  want.matched, i_matched));
                    end
                    if (i_match_score !== want.score) begin
                        report_mismatch($sformatf("match_score: expected %0d, got %0d",
                                                  want.score, i_match_score));
                    end
                    if (i_length_saturated !== want.saturated) begin
                        report_mismatch($sformatf("length_saturated: expected %0d, got %0b",
                                                  want.saturated, i_length_saturated));
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:3]))
                    REG_NEEDLE_LOW:  needle_lo  = i_pwdata;
                    REG_NEEDLE_HIGH: needle_hi  = i_pwdata;
                    REG_NEEDLE_LEN:  needle_len = i_pwdata[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                score_byte(i_path_byte, i_last_byte);
            end
        end
        o_results_pending <= verdict_queue.size();
        o_fail_count      <= mismatch_count;
    end

endmodule

`default_nettype wire

>>> sim/tb_fuzzy_path_match_scorer.sv
`default_nettype none

// Top of the scorer testbench: clock, reset, stimulus and the verdict.
// Result comparison lives in path_score_checker, which sits beside the block.
module tb_fuzzy_path_match_scorer;
    timeunit 1ns;
    timeprecision 1ps;

    import fpms_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 4;
    localparam int ITEMS_PER_ROUND  = 80;    // 8 rounds; at least 640 items in all
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum int {
        NEEDLE_ALL_ONES,
        NEEDLE_EMPTY,
        NEEDLE_RANDOM
    } t_needle_kind;

    // idle mix per round, cycled: none, sender only, receiver only, both
    localparam int GAP_PCT[4]   = '{0, 47, 0, 35};
    localparam int STALL_PCT[4] = '{0, 0, 47, 35};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_path_byte = '0;
    logic        i_last_byte = 1'b0;

    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_matched;
    logic signed [SCORE_W-1:0] o_match_score;
    logic                      o_length_saturated;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int results_pending;

    // stimulus knobs; stall_pct and long_hold_req are read by the stall
    // process, so they only change through nonblocking writes
    int unsigned gap_pct        = 0;
    int unsigned stall_pct      = 0;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;
    int unsigned hold_left      = 0;

    // needle as last programmed, used to steer path generation
    logic [7:0] needle_chars[16];
    int unsigned needle_len = 0;

    logic [7:0] path_buf[$];
    int unsigned items_sent = 0;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    fuzzy_path_match_scorer u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_path_byte        (i_path_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_matched          (o_matched),
        .o_match_score      (o_match_score),
        .o_length_saturated (o_length_saturated),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    path_score_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_path_byte        (i_path_byte),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_matched          (o_matched),
        .i_match_score      (o_match_score),
        .i_length_saturated (o_length_saturated),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_pready           (pready),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_fail_count       (fail_count),
        .o_results_pending  (results_pending)
    );

    // Result side back-pressure. A long hold, once requested, wins over the
    // random stalls and keeps the result channel blocked long enough that
    // the block backs up into its input channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            i_out_stall    <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Swap case of ASCII letters, leave everything else alone.
    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic int unsigned active_len();
        return (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : needle_len;
    endfunction

    // Append one byte to the path being built.
    function automatic void add_path_byte(input logic [7:0] c);
        path_buf = {path_buf, c};
    endfunction

    // Filler byte for a path: mostly letters, digits and separators, some
    // punctuation (word boundaries), some needle bytes in either case and
    // the odd fully random byte.
    function automatic logic [7:0] pick_filler();
        case ($urandom_range(9))
            0, 1: return 8'(8'h61 + $urandom_range(25));
            2:    return 8'(8'h41 + $urandom_range(25));
            3:    return 8'(8'h30 + $urandom_range(9));
            4:    return CH_SLASH;
            5:    return CH_BACKSLASH;
            6: begin
                case ($urandom_range(2))
                    0:       return "_";
                    1:       return ".";
                    default: return "-";
                endcase
            end
            7: return 8'($urandom_range(255));
            default: begin
                if (active_len() == 0) begin
                    return 8'($urandom_range(255));
                end
                return $urandom_range(1) ? flip_case(needle_chars[$urandom_range(active_len()-1)])
                                         : needle_chars[$urandom_range(active_len()-1)];
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_needle_char();
        case ($urandom_range(7))
            0, 1, 2, 3: begin
                return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25));
            end
            4:       return 8'(8'h30 + $urandom_range(9));
            5:       return $urandom_range(1) ? CH_SLASH : CH_BACKSLASH;
            6:       return $urandom_range(1) ? "_" : ".";
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Build the next path in path_buf. Most paths carry the needle spread
    // out between filler, with random case and now and then a byte dropped
    // so the path misses; the rest are plain noise.
    function automatic void make_path();
        path_buf.delete();
        if (active_len() == 0 || $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 24)) add_path_byte(pick_filler());
        end else begin
            for (int unsigned i = 0; i < active_len(); i++) begin
                repeat ($urandom_range(3)) add_path_byte(pick_filler());
                if ($urandom_range(19) != 0) begin
                    add_path_byte(($urandom_range(9) < 3) ? flip_case(needle_chars[i])
                                                          : needle_chars[i]);
                end
            end
            repeat ($urandom_range(3)) add_path_byte(pick_filler());
        end
        if (path_buf.size() == 0) begin
            add_path_byte(pick_filler());
        end
    endfunction

    // One APB write: setup, access, then release of the port.
    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_needle(input t_needle_kind kind);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < 16; i++) begin
            case (kind)
                NEEDLE_ALL_ONES: needle_chars[i] = 8'hFF;
                NEEDLE_EMPTY:    needle_chars[i] = 8'h00;
                default:         needle_chars[i] = pick_needle_char();
            endcase
        end
        case (kind)
            NEEDLE_ALL_ONES: needle_len = 31;   // clamps to the full 16 bytes
            NEEDLE_EMPTY:    needle_len = 0;
            default: begin
                case ($urandom_range(19))
                    0:          needle_len = $urandom_range(17, 31);
                    1, 2:       needle_len = NEEDLE_MAX;
                    3, 4, 5:    needle_len = $urandom_range(7, 16);
                    default:    needle_len = $urandom_range(1, 6);
                endcase
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = needle_chars[i];
            hi[8*i +: 8] = needle_chars[i+8];
        end
        apb_write(REG_NEEDLE_LOW, lo);
        apb_write(REG_NEEDLE_HIGH, hi);
        apb_write(REG_NEEDLE_LEN, DATA_W'(needle_len));
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_path_byte <= value;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_path();
        foreach (path_buf[i]) begin
            send_byte(path_buf[i], i == path_buf.size() - 1);
        end
    endtask

    // Stop offering, let every outstanding result drain, then let the
    // pipeline settle before anything touches the registers.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed paths ---
        // empty needle straight out of reset, extreme byte values
        path_buf = '{8'h00, 8'hFF};
        send_path();

        // needle "//ab": separator at path start, separator after separator,
        // folded-case match after a separator, exact match
        wait_idle();
        apb_write(REG_NEEDLE_LOW, 64'h0000_0000_6261_2F2F);
        apb_write(REG_NEEDLE_HIGH, '1);
        apb_write(REG_NEEDLE_LEN, 64'd4);
        path_buf = '{CH_SLASH, CH_SLASH, "A", "b"};
        send_path();
        // miss: needle never completes, score field must read zero
        path_buf = '{"q", CH_SLASH, "x"};
        send_path();

        // needle "ab": start-of-path bonus wiped by a separator, then a
        // folded-case match inside the last segment
        wait_idle();
        apb_write(REG_NEEDLE_LOW, 64'h0000_0000_0000_6261);
        apb_write(REG_NEEDLE_LEN, 64'd2);
        path_buf = '{"a", CH_SLASH, "x", "_", "a", "B"};
        send_path();
        // needle complete, a later separator still clears the pending bonus
        path_buf = '{"a", "b", CH_BACKSLASH, "c"};
        send_path();

        // --- random rounds, one needle each, cycling the idle mix ---
        for (int r = 0; r < 8; r++) begin
            wait_idle();
            case (r)
                0:       program_needle(NEEDLE_ALL_ONES);
                1:       program_needle(NEEDLE_EMPTY);
                default: program_needle(NEEDLE_RANDOM);
            endcase
            gap_pct   =  GAP_PCT[r % 4];
            stall_pct <= STALL_PCT[r % 4];
            items_sent = 0;
            while (items_sent < ITEMS_PER_ROUND) begin
                make_path();
                send_path();
            end
        end

        // --- back-pressure: short paths pour in while results are held off,
        // so the block fills and has to stall the input side ---
        wait_idle();
        program_needle(NEEDLE_RANDOM);
        gap_pct        = 0;
        stall_pct     <= 0;
        long_hold_req <= 1'b1;
        repeat (80) begin
            path_buf.delete();
            repeat ($urandom_range(1, 2)) add_path_byte(pick_filler());
            send_path();
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/fpms_pkg.sv
design/fuzzy_path_match_scorer.sv
design/fpms_checker.sv
sim/path_score_checker.sv
sim/tb_fuzzy_path_match_scorer.sv
